// ===== hdl/ecu_can_frame_decoder_top_macros.svh =====
// Assertion helpers used by the top-level file that checks this block.
`ifndef ECU_CAN_FRAME_DECODER_TOP_MACROS_SVH
`define ECU_CAN_FRAME_DECODER_TOP_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ECU_ASSERT_NOW(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define ECU_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hdl/ecu_cfd_pkg.sv =====
package ecu_cfd_pkg;

    localparam int TABLE_DEPTH = 1024;
    localparam int ADDR_W      = $clog2(TABLE_DEPTH);
    localparam int FILL_W      = $clog2(TABLE_DEPTH + 1);
    localparam int TOTAL_W     = 11;

    localparam logic [31:0] ID_SPEED  = 32'h8CFF_F048;
    localparam logic [31:0] ID_PRESS  = 32'h8CFF_F148;
    localparam logic [31:0] ID_ANALOG = 32'h8CFF_F348;
    localparam logic [31:0] ID_TEMP   = 32'h8CFF_F548;

    // Reciprocals scaled by 2^RECIP_SHIFT, rounded up; exact for magnitudes up to 2^16.
    localparam int          RECIP_SHIFT = 26;
    localparam int          RECIP_W     = 27;
    localparam int          PROD_W      = 16 + RECIP_W;
    localparam logic [RECIP_W-1:0] RECIP_1    = RECIP_W'(67108864);
    localparam logic [RECIP_W-1:0] RECIP_10   = RECIP_W'(6710887);
    localparam logic [RECIP_W-1:0] RECIP_100  = RECIP_W'(671089);
    localparam logic [RECIP_W-1:0] RECIP_1000 = RECIP_W'(67109);

    localparam int QUEUE_DEPTH = 2;

    typedef enum logic [2:0] {
        KIND_SPEED   = 3'd0,
        KIND_PRESS   = 3'd1,
        KIND_ANALOG  = 3'd2,
        KIND_TEMP    = 3'd3,
        KIND_UNKNOWN = 3'd4
    } kind_t;

    typedef enum logic [1:0] {
        ST_KNOWN  = 2'd0,
        ST_LISTED = 2'd1,
        ST_ADDED  = 2'd2,
        ST_FULL   = 2'd3
    } id_status_t;

    typedef struct packed {
        kind_t        kind;
        logic [31:0]  frame_id;
        logic [63:0]  payload;
    } frame_t;

    typedef struct packed {
        logic full;
        logic empty;
    } queue_stat_t;

endpackage

// ===== hdl/ecu_cfd_front.sv =====
module ecu_cfd_front
    import ecu_cfd_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [95:0] s_tdata,
    output logic        push_valid,
    input  logic        push_ready,
    output frame_t      push_frame
);

    logic   hold_valid_reg;
    logic   hold_valid_next;
    frame_t hold_reg;
    frame_t hold_next;
    kind_t  kind;
    logic   push;

    always_comb begin
        case (s_tdata[31:0])
            ID_SPEED:  kind = KIND_SPEED;
            ID_PRESS:  kind = KIND_PRESS;
            ID_ANALOG: kind = KIND_ANALOG;
            ID_TEMP:   kind = KIND_TEMP;
            default:   kind = KIND_UNKNOWN;
        endcase
    end

    assign push       = hold_valid_reg && push_ready;
    assign s_tready   = !hold_valid_reg || push;
    assign push_valid = hold_valid_reg;
    assign push_frame = hold_reg;

    always_comb begin
        hold_valid_next = hold_valid_reg;
        hold_next       = hold_reg;
        if (push) begin
            hold_valid_next = 1'b0;
        end
        if (s_tvalid && s_tready) begin
            hold_valid_next    = 1'b1;
            hold_next.kind     = kind;
            hold_next.frame_id = s_tdata[31:0];
            hold_next.payload  = s_tdata[95:32];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hold_valid_reg <= 1'b0;
        end else begin
            hold_valid_reg <= hold_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        hold_reg <= hold_next;
    end

endmodule

// ===== hdl/ecu_cfd_queue.sv =====
module ecu_cfd_queue
    import ecu_cfd_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        push_valid,
    output logic        push_ready,
    input  frame_t      push_frame,
    output logic        pop_valid,
    input  logic        pop_ready,
    output frame_t      pop_frame,
    output queue_stat_t stat
);

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    frame_t             slots_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg;
    logic [PTR_W-1:0]   wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_reg;
    logic [PTR_W-1:0]   rd_ptr_next;
    logic [CNT_W-1:0]   count_reg;
    logic [CNT_W-1:0]   count_next;
    logic               do_push;
    logic               do_pop;

    assign stat.full  = (count_reg == CNT_W'(QUEUE_DEPTH));
    assign stat.empty = (count_reg == '0);
    assign push_ready = !stat.full;
    assign pop_valid  = !stat.empty;
    assign pop_frame  = slots_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop) begin
            count_next = count_reg + 1'b1;
        end else if (do_pop && !do_push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            slots_reg[wr_ptr_reg] <= push_frame;
        end
    end

endmodule

// ===== hdl/ecu_cfd_back.sv =====
module ecu_cfd_back
    import ecu_cfd_pkg::*;
(
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         pop_valid,
    output logic         pop_ready,
    input  frame_t       pop_frame,
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [135:0] m_tdata,
    output logic [2:0]   m_tuser
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_MUL,
        S_FIN,
        S_SCAN,
        S_DONE
    } state_t;

    typedef enum logic [1:0] {
        DIV_1,
        DIV_10,
        DIV_100,
        DIV_1000
    } div_t;

    state_t              state_reg, state_next;
    frame_t              cur_reg, cur_next;
    logic [1:0]          fld_reg, fld_next;
    logic [PROD_W-1:0]   prod_reg, prod_next;
    logic                neg_reg, neg_next;
    logic [16:0]         vals_reg [4];
    logic [16:0]         vals_next [4];
    id_status_t          status_reg, status_next;
    logic [FILL_W-1:0]   idx_reg, idx_next;
    logic                pend_reg, pend_next;
    logic [FILL_W-1:0]   fill_reg, fill_next;
    logic [15:0]         rpm_reg, rpm_next;
    logic [12:0]         throttle_reg, throttle_next;
    logic [12:0]         coolant_reg, coolant_next;
    logic [9:0]          battery_reg, battery_next;
    logic                out_valid_reg, out_valid_next;
    logic [135:0]        out_data_reg, out_data_next;
    kind_t               out_kind_reg, out_kind_next;

    logic [31:0]         mem [TABLE_DEPTH];
    logic [31:0]         rd_data_reg;
    logic                rd_en;
    logic [ADDR_W-1:0]   rd_addr;
    logic                wr_en;
    logic [ADDR_W-1:0]   wr_addr;

    logic [15:0]         raw;
    logic                sgn;
    div_t                div;
    logic [RECIP_W-1:0]  recip;
    logic [15:0]         mag;
    logic [16:0]         quot;
    logic                table_full;

    assign table_full = (fill_reg >= FILL_W'(TABLE_DEPTH));
    assign pop_ready  = (state_reg == S_IDLE);
    assign m_tvalid   = out_valid_reg;
    assign m_tdata    = out_data_reg;
    assign m_tuser    = out_kind_reg;

    // Field selection and scaling rule for the field under work.
    always_comb begin
        raw = cur_reg.payload[{fld_reg, 4'b0000} +: 16];
        sgn = 1'b1;
        div = DIV_1;
        case (cur_reg.kind)
            KIND_SPEED: begin
                if (fld_reg == 2'd0) sgn = 1'b0;
                if (fld_reg == 2'd1) div = DIV_10;
            end
            KIND_PRESS: begin
                if (fld_reg == 2'd3) begin
                    raw = {8'h00, cur_reg.payload[55:48]};
                    sgn = 1'b0;
                end
            end
            KIND_ANALOG: begin
                div = DIV_1000;
            end
            KIND_TEMP: begin
                if (fld_reg == 2'd0) div = DIV_100;
                if (fld_reg == 2'd1 || fld_reg == 2'd2) div = DIV_10;
                if (fld_reg == 2'd3) begin
                    raw = {8'h00, cur_reg.payload[55:48]};
                    sgn = 1'b0;
                end
            end
            default: begin
                sgn = 1'b0;
            end
        endcase
        case (div)
            DIV_10:   recip = RECIP_10;
            DIV_100:  recip = RECIP_100;
            DIV_1000: recip = RECIP_1000;
            default:  recip = RECIP_1;
        endcase
        mag  = (sgn && raw[15]) ? (~raw + 16'd1) : raw;
        quot = prod_reg[RECIP_SHIFT +: 17];
    end

    always_comb begin
        state_next     = state_reg;
        cur_next       = cur_reg;
        fld_next       = fld_reg;
        prod_next      = prod_reg;
        neg_next       = neg_reg;
        vals_next      = vals_reg;
        status_next    = status_reg;
        idx_next       = idx_reg;
        pend_next      = 1'b0;
        fill_next      = fill_reg;
        rpm_next       = rpm_reg;
        throttle_next  = throttle_reg;
        coolant_next   = coolant_reg;
        battery_next   = battery_reg;
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        out_kind_next  = out_kind_reg;
        rd_en          = 1'b0;
        rd_addr        = idx_reg[ADDR_W-1:0];
        wr_en          = 1'b0;
        wr_addr        = fill_reg[ADDR_W-1:0];

        if (out_valid_reg && m_tready) begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE: begin
                if (pop_valid) begin
                    cur_next    = pop_frame;
                    fld_next    = 2'd0;
                    idx_next    = '0;
                    status_next = ST_KNOWN;
                    for (int i = 0; i < 4; i++) vals_next[i] = '0;
                    if (pop_frame.kind != KIND_UNKNOWN) begin
                        state_next = S_MUL;
                    end else if (pop_frame.frame_id == '0) begin
                        status_next = table_full ? ST_FULL : ST_LISTED;
                        state_next  = S_DONE;
                    end else begin
                        state_next = S_SCAN;
                    end
                end
            end
            S_MUL: begin
                prod_next  = PROD_W'(mag) * PROD_W'(recip);
                neg_next   = sgn && raw[15];
                state_next = S_FIN;
            end
            S_FIN: begin
                vals_next[fld_reg] = neg_reg ? (~quot + 17'd1) : quot;
                fld_next           = fld_reg + 2'd1;
                state_next         = (fld_reg == 2'd3) ? S_DONE : S_MUL;
            end
            S_SCAN: begin
                // Compare last cycle's read, issue the next one, or append on a miss.
                if (pend_reg && rd_data_reg == cur_reg.frame_id) begin
                    status_next = ST_LISTED;
                    state_next  = S_DONE;
                end else if (idx_reg < fill_reg) begin
                    rd_en     = 1'b1;
                    idx_next  = idx_reg + 1'b1;
                    pend_next = 1'b1;
                end else if (!pend_reg) begin
                    if (table_full) begin
                        status_next = ST_FULL;
                    end else begin
                        wr_en       = 1'b1;
                        fill_next   = fill_reg + 1'b1;
                        status_next = ST_ADDED;
                    end
                    state_next = S_DONE;
                end
            end
            S_DONE: begin
                if (!out_valid_reg || m_tready) begin
                    if (cur_reg.kind == KIND_SPEED) begin
                        rpm_next      = vals_reg[0][15:0];
                        throttle_next = vals_reg[1][12:0];
                    end
                    if (cur_reg.kind == KIND_TEMP) begin
                        battery_next = vals_reg[0][9:0];
                        coolant_next = vals_reg[2][12:0];
                    end
                    out_valid_next = 1'b1;
                    out_kind_next  = cur_reg.kind;
                    out_data_next  = {6'b0,
                                      battery_next,
                                      coolant_next,
                                      throttle_next,
                                      rpm_next,
                                      TOTAL_W'(fill_reg),
                                      status_reg,
                                      vals_reg[3][15:0],
                                      vals_reg[2][15:0],
                                      vals_reg[1][15:0],
                                      vals_reg[0]};
                    state_next     = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_IDLE;
            pend_reg      <= 1'b0;
            fill_reg      <= '0;
            rpm_reg       <= '0;
            throttle_reg  <= '0;
            coolant_reg   <= '0;
            battery_reg   <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            pend_reg      <= pend_next;
            fill_reg      <= fill_next;
            rpm_reg       <= rpm_next;
            throttle_reg  <= throttle_next;
            coolant_reg   <= coolant_next;
            battery_reg   <= battery_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        cur_reg      <= cur_next;
        fld_reg      <= fld_next;
        prod_reg     <= prod_next;
        neg_reg      <= neg_next;
        vals_reg     <= vals_next;
        status_reg   <= status_next;
        idx_reg      <= idx_next;
        out_data_reg <= out_data_next;
        out_kind_reg <= out_kind_next;
    end

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= cur_reg.frame_id;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

endmodule

// ===== hdl/ecu_can_frame_decoder_top.sv =====
// Engine-controller CAN frame decoder.
// Input stream (s_): one beat per received frame, tdata = frame_id in [31:0]
// and the eight payload bytes in [95:32], byte 0 lowest.
// Output stream (m_): one beat per frame, tuser = frame kind, tdata = scaled
// fields, identifier status, unknown-table fill and the latched dashboard values.
// Known frames share one reciprocal multiplier among their four fields; each
// field passes through a multiply state and then a finish state.
// Unknown nonzero identifiers walk the 1024-entry table one entry a cycle
// through its single read port; a zero identifier skips the walk.
// The decode engine takes a new frame only after it has finished the last one
// and returned to idle.
// A two-beat queue sits between the classifier and the decode engine, so up
// to three frames may be accepted ahead of the one being decoded.
// Reset empties the queue, zeroes the fill count and the latched values;
// the table contents need no sweep since only filled entries are compared.
// When the receiver stalls, the finished beat holds in the output register,
// the engine waits, and input stalls once the queue and front register fill.
`include "ecu_can_frame_decoder_top_macros.svh"

module ecu_can_frame_decoder_top
    import ecu_cfd_pkg::*;
(
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [95:0]  s_tdata,   // frame_id[31:0], payload[95:32]
    output logic         m_tvalid,
    input  logic         m_tready,
    // value_first[16:0], value_second[32:17], value_third[48:33],
    // value_fourth[64:49], id_status[66:65], unknown_total[77:67],
    // rpm_latest[93:78], throttle_latest[106:94], coolant_latest[119:107],
    // battery_latest[129:120], zero pad[135:130]
    output logic [135:0] m_tdata,
    output logic [2:0]   m_tuser    // frame_kind[2:0]
);

    logic        push_valid;
    logic        push_ready;
    frame_t      push_frame;
    logic        pop_valid;
    logic        pop_ready;
    frame_t      pop_frame;
    queue_stat_t q_stat;

    // Classify and register the incoming beat.
    ecu_cfd_front u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_frame (push_frame)
    );

    // Decouple the classifier from the decode engine.
    ecu_cfd_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_frame (push_frame),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_frame  (pop_frame),
        .stat       (q_stat)
    );

    // Scale fields, track unknown identifiers, hold the result beat.
    ecu_cfd_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .pop_valid (pop_valid),
        .pop_ready (pop_ready),
        .pop_frame (pop_frame),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    // Only unknown frames carry a nonzero identifier status.
    `ECU_ASSERT_NOW(a_status_kind, aclk, aresetn, m_tvalid, ((m_tuser == KIND_UNKNOWN) || (m_tdata[66:65] == ST_KNOWN)), "known frame with table status")
    // A speed frame result shows its own rpm as the latched value.
    `ECU_ASSERT_NOW(a_rpm_latch, aclk, aresetn, m_tvalid && (m_tuser == KIND_SPEED), (m_tdata[93:78] == m_tdata[15:0]), "rpm not latched")
    // A newly added identifier leaves the table non-empty.
    `ECU_ASSERT_NOW(a_added_fill, aclk, aresetn, m_tvalid && (m_tdata[66:65] == ST_ADDED), (m_tdata[77:67] != '0), "added id with empty table")
    // A full queue with a frame waiting upstream stalls the input side.
    `ECU_ASSERT_NOW(a_queue_stall, aclk, aresetn, q_stat.full && push_valid, !s_tready, "input accepted while queue full")

endmodule
